[rtl/bfcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bfcd_pkg;

  localparam int FRAME_DEPTH = 32;
  localparam int WP_W        = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W       = $clog2(FRAME_DEPTH);
  localparam int WINDOW      = 9;
  localparam int KIND_W      = 3;

  typedef logic [7:0] byte_t;

  localparam byte_t CHAR_OPEN  = 8'h7B;
  localparam byte_t CHAR_CLOSE = 8'h7D;
  localparam byte_t CHAR_G     = 8'h47;
  localparam byte_t CHAR_O     = 8'h4F;
  localparam byte_t CHAR_E     = 8'h45;
  localparam byte_t CHAR_N     = 8'h4E;
  localparam byte_t CHAR_D     = 8'h44;
  localparam byte_t CHAR_S     = 8'h53;
  localparam byte_t CHAR_A     = 8'h41;
  localparam byte_t CHAR_M     = 8'h4D;

  typedef enum logic [KIND_W-1:0] {
    CMD_UNKNOWN = 3'd0,
    CMD_GO      = 3'd1,
    CMD_END     = 3'd2,
    CMD_SENSOR  = 3'd3,
    CMD_ALERT   = 3'd4,
    CMD_PAYMENT = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    logic                     close;
    logic                     framed;
    byte_t [WINDOW-1:0]       field;
  } frame_view_t;

  typedef struct packed {
    cmd_kind_t    kind;
    logic [15:0]  money;
    byte_t        hunger;
    byte_t        happy;
    byte_t        thirst;
    logic [63:0]  text;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/bfcd_rx_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bfcd_rx_if import bfcd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/bfcd_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bfcd_cmd_if import bfcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] cmd_kind;
  logic [15:0]       money_value;
  byte_t             hunger_level;
  byte_t             happy_level;
  byte_t             thirst_level;
  logic [63:0]       alert_text;

  modport source (
    output valid, output cmd_kind, output money_value, output hunger_level,
    output happy_level, output thirst_level, output alert_text, input ready
  );
  modport sink (
    input valid, input cmd_kind, input money_value, input hunger_level,
    input happy_level, input thirst_level, input alert_text, output ready
  );
endinterface

`default_nettype wire

[rtl/bfcd_frame_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfcd_frame_tracker import bfcd_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         accept,
  input  byte_t       rx_byte,
  output frame_view_t view
);

  byte_t              store [FRAME_DEPTH];
  byte_t              store_next [FRAME_DEPTH];
  logic [WP_W-1:0]    wr_pos, wr_pos_next;
  logic [WP_W-1:0]    open_pos, open_pos_next;
  logic               open_seen, open_seen_next;
  byte_t [WINDOW-1:0] ahead, ahead_next;
  byte_t [WINDOW-1:0] field, field_next;

  logic               room;
  logic [IDX_W-1:0]   wr_idx;
  logic               is_open;
  logic               is_close;
  logic [WP_W:0]      far_pos;
  byte_t              far_byte;
  logic [WP_W-1:0]    offset;
  logic               write_en;

  // The ahead window holds the store bytes just past the write position, so
  // the nine field bytes behind an opening brace can be captured at once.
  always_comb begin
    room     = wr_pos < WP_W'(FRAME_DEPTH);
    wr_idx   = wr_pos[IDX_W-1:0];
    is_open  = rx_byte == CHAR_OPEN;
    is_close = rx_byte == CHAR_CLOSE;
    write_en = accept && room;
    far_pos  = {1'b0, wr_pos} + (WP_W + 1)'(WINDOW + 1);
    far_byte = (far_pos < (WP_W + 1)'(FRAME_DEPTH)) ? store[far_pos[IDX_W-1:0]] : '0;
    offset   = wr_pos - open_pos;
  end

  always_comb begin
    for (int k = 0; k < FRAME_DEPTH; k++) begin
      store_next[k] = (write_en && wr_idx == IDX_W'(k)) ? rx_byte : store[k];
    end
  end

  always_comb begin
    field_next = field;
    if (write_en && open_seen) begin
      for (int j = 0; j < WINDOW; j++) begin
        if (offset == WP_W'(j + 1)) begin
          field_next[j] = rx_byte;
        end
      end
    end else if (write_en && is_open) begin
      field_next = ahead;
    end
  end

  always_comb begin
    ahead_next     = ahead;
    wr_pos_next    = wr_pos;
    open_pos_next  = open_pos;
    open_seen_next = open_seen;
    if (accept && is_close) begin
      for (int j = 0; j < WINDOW; j++) begin
        ahead_next[j] = store_next[j + 1];
      end
      wr_pos_next    = '0;
      open_pos_next  = '0;
      open_seen_next = 1'b0;
    end else if (write_en) begin
      for (int j = 0; j < WINDOW - 1; j++) begin
        ahead_next[j] = ahead[j + 1];
      end
      ahead_next[WINDOW-1] = far_byte;
      wr_pos_next          = wr_pos + WP_W'(1);
      if (is_open && !open_seen) begin
        open_seen_next = 1'b1;
        open_pos_next  = wr_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FRAME_DEPTH; k++) begin
        store[k] <= '0;
      end
      wr_pos    <= '0;
      open_pos  <= '0;
      open_seen <= 1'b0;
      ahead     <= '0;
      field     <= '0;
    end else begin
      for (int k = 0; k < FRAME_DEPTH; k++) begin
        store[k] <= store_next[k];
      end
      wr_pos    <= wr_pos_next;
      open_pos  <= open_pos_next;
      open_seen <= open_seen_next;
      ahead     <= ahead_next;
      field     <= field_next;
    end
  end

  assign view.close  = is_close;
  assign view.framed = open_seen;
  assign view.field  = field_next;

endmodule

`default_nettype wire

[rtl/bfcd_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfcd_decoder import bfcd_pkg::*; (
  input  frame_view_t view,
  output cmd_t        cmd
);

  byte_t c1, c2, c3, c4;

  always_comb begin
    c1  = view.field[0];
    c2  = view.field[1];
    c3  = view.field[2];
    c4  = view.field[3];
    cmd = '0;
    cmd.kind = CMD_UNKNOWN;
    if (view.framed) begin
      if (c1 == CHAR_G && c2 == CHAR_O) begin
        cmd.kind  = CMD_GO;
        cmd.money = {c3, c4};
      end else if (c1 == CHAR_E && c2 == CHAR_N && c3 == CHAR_D) begin
        cmd.kind = CMD_END;
      end else if (c1 == CHAR_S) begin
        cmd.kind   = CMD_SENSOR;
        cmd.hunger = c2;
        cmd.happy  = c3;
        cmd.thirst = c4;
      end else if (c1 == CHAR_A) begin
        cmd.kind = CMD_ALERT;
        cmd.text = {view.field[1], view.field[2], view.field[3], view.field[4],
                    view.field[5], view.field[6], view.field[7], view.field[8]};
      end else if (c1 == CHAR_M) begin
        cmd.kind  = CMD_PAYMENT;
        cmd.money = {c2, c3};
      end
    end
  end

endmodule

`default_nettype wire

[rtl/brace_frame_command_decoder.sv]
// Brace-framed command decoder. Received bytes arrive one beat at a time on
// rx and are written into a 32-byte frame store; the first '{' of a frame
// is remembered, and each '}' yields one decoded command beat on cmd (go,
// end, sensor, alert, payment or unknown) in the cycle after it is taken. A
// byte is accepted every cycle while the output register is empty or being
// drained, so the sustained rate is one byte per clock; the output register
// alone decides back-pressure. The store is cleared by reset and not between
// frames, so field bytes beyond a short frame read older contents.
`timescale 1ns / 1ps
`default_nettype none

module brace_frame_command_decoder import bfcd_pkg::*; (
  input wire          clk,
  input wire          rst,
  bfcd_rx_if.sink     rx,
  bfcd_cmd_if.source  cmd
);

  logic        accept;
  frame_view_t view;
  cmd_t        decoded;
  cmd_t        result;
  logic        out_valid, out_valid_next;

  assign rx.ready = !out_valid || cmd.ready;
  assign accept   = rx.valid && rx.ready;

  bfcd_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .view    (view)
  );

  bfcd_decoder u_decoder (
    .view (view),
    .cmd  (decoded)
  );

  always_comb begin
    out_valid_next = out_valid && !cmd.ready;
    if (accept && view.close) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && view.close) begin
      result <= decoded;
    end
  end

  assign cmd.valid        = out_valid;
  assign cmd.cmd_kind     = result.kind;
  assign cmd.money_value  = result.money;
  assign cmd.hunger_level = result.hunger;
  assign cmd.happy_level  = result.happy;
  assign cmd.thirst_level = result.thirst;
  assign cmd.alert_text   = result.text;

  a_close_gives_beat: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready && rx.rx_byte == CHAR_CLOSE |=> cmd.valid)
    else $error("closing brace did not produce a command beat");

  a_no_spurious_beat: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready && rx.rx_byte != CHAR_CLOSE && !(cmd.valid && !cmd.ready)
    |=> !cmd.valid)
    else $error("command beat without a closing brace");

  a_money_only_go_pay: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.cmd_kind != CMD_GO && cmd.cmd_kind != CMD_PAYMENT
    |-> cmd.money_value == '0)
    else $error("money value set on a command that carries none");

  a_text_only_alert: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.cmd_kind != CMD_ALERT |-> cmd.alert_text == '0)
    else $error("alert text set on a non-alert command");

endmodule

`default_nettype wire

[verif/brace_frame_command_decoder_tb.sv]
`timescale 1ns / 1ps

module brace_frame_command_decoder_tb import bfcd_pkg::*; ();

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int TARGET_BYTES = 500;

  localparam int RCV_ALWAYS  = 0;
  localparam int RCV_RANDOM  = 1;
  localparam int RCV_PATTERN = 2;

  logic clk = 1'b0;
  logic rst;

  bfcd_rx_if  rx_ch ();
  bfcd_cmd_if cmd_ch ();

  brace_frame_command_decoder i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cmd (cmd_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the frame store and its pointers.
  byte_t frame_copy [FRAME_DEPTH];
  int    wr_pos;
  int    open_pos;
  bit    open_flag;

  cmd_t  pending_cmds [$];
  cmd_t  want_cmd;
  int    mismatch_count = 0;
  int    rx_count = 0;
  int    idle_cycles = 0;

  int    gap_max = 0;
  int    burst_left = 0;
  int    rcv_mode = RCV_ALWAYS;
  int    rcv_cycle = 0;
  bit    hold_req = 1'b0;
  int    hold_len = 0;

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic byte_t frame_byte(input int offset);
    int p;
    p = open_pos + offset;
    if (p >= FRAME_DEPTH) begin
      return '0;
    end
    return frame_copy[p];
  endfunction

  function automatic bit decode_rx_byte(input byte_t b, output cmd_t res);
    byte_t f1, f2, f3;
    res = '0;
    if (wr_pos < FRAME_DEPTH) begin
      frame_copy[wr_pos] = b;
      if (b == CHAR_OPEN && !open_flag) begin
        open_flag = 1'b1;
        open_pos  = wr_pos;
      end
      wr_pos++;
    end
    if (b != CHAR_CLOSE) begin
      return 1'b0;
    end
    if (open_flag) begin
      f1 = frame_byte(1);
      f2 = frame_byte(2);
      f3 = frame_byte(3);
      if (f1 == CHAR_G && f2 == CHAR_O) begin
        res.kind  = CMD_GO;
        res.money = {f3, frame_byte(4)};
      end else if (f1 == CHAR_E && f2 == CHAR_N && f3 == CHAR_D) begin
        res.kind = CMD_END;
      end else if (f1 == CHAR_S) begin
        res.kind   = CMD_SENSOR;
        res.hunger = f2;
        res.happy  = f3;
        res.thirst = frame_byte(4);
      end else if (f1 == CHAR_A) begin
        res.kind = CMD_ALERT;
        for (int i = 0; i < 8; i++) begin
          res.text = {res.text[55:0], frame_byte(2 + i)};
        end
      end else if (f1 == CHAR_M) begin
        res.kind  = CMD_PAYMENT;
        res.money = {f2, f3};
      end
    end
    wr_pos    = 0;
    open_pos  = 0;
    open_flag = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input byte_t b);
    int   gap;
    cmd_t res;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          rx_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    if (decode_rx_byte(b, res)) begin
      pending_cmds.push_back(res);
    end
    rx_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_cmds.size() != 0);
  endtask

  task automatic test_stale_after_reset();
    send_byte(CHAR_OPEN);
    send_byte(CHAR_M);
    send_byte(CHAR_CLOSE);
    send_byte(CHAR_OPEN);
    send_byte(CHAR_A);
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_go();
    send_byte(CHAR_OPEN);
    send_byte(CHAR_G);
    send_byte(CHAR_O);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_end();
    send_byte(CHAR_OPEN);
    send_byte(CHAR_E);
    send_byte(CHAR_N);
    send_byte(CHAR_D);
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_sensor();
    send_byte(CHAR_OPEN);
    send_byte(CHAR_S);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_alert();
    send_byte(CHAR_OPEN);
    send_byte(CHAR_A);
    for (int i = 0; i < 8; i++) begin
      send_byte(byte_t'(8'hA5 ^ (i * 8'h1F)));
    end
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_payment();
    send_byte(CHAR_OPEN);
    send_byte(CHAR_M);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_unknown();
    send_byte(CHAR_OPEN);
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_no_open();
    send_byte(8'h00);
    send_byte(CHAR_CLOSE);
  endtask

  // The open brace lands in the last two slots, so fields fall beyond the store,
  // and then a frame overruns the store with no open brace at all.
  task automatic test_store_full();
    for (int i = 0; i < FRAME_DEPTH - 2; i++) begin
      send_byte(byte_t'(8'h20 + i));
    end
    send_byte(CHAR_OPEN);
    send_byte(CHAR_A);
    send_byte(8'hFF);
    send_byte(CHAR_OPEN);
    send_byte(CHAR_CLOSE);
    for (int i = 0; i < FRAME_DEPTH + 1; i++) begin
      send_byte(byte_t'(8'h30 + i));
    end
    send_byte(CHAR_CLOSE);
  endtask

  task automatic send_random_frame();
    byte_t body [$];
    int    pick;
    int    cut;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(rand_byte());
    end
    if ($urandom_range(0, 29) == 0) begin
      repeat ($urandom_range(FRAME_DEPTH - 6, FRAME_DEPTH + 2)) begin
        send_byte(byte_t'($urandom_range(8'h20, 8'h7A)));
      end
    end
    pick = $urandom_range(0, 6);
    case (pick)
      0: begin
        body.push_back(CHAR_G);
        body.push_back(CHAR_O);
        repeat (2) body.push_back(rand_byte());
      end
      1: begin
        body.push_back(CHAR_E);
        body.push_back(CHAR_N);
        body.push_back(CHAR_D);
        if ($urandom_range(0, 3) == 0) begin
          body[$urandom_range(0, 2)] = rand_byte();
        end
      end
      2: begin
        body.push_back(CHAR_S);
        repeat (3) body.push_back(rand_byte());
      end
      3: begin
        body.push_back(CHAR_A);
        repeat (8) body.push_back(rand_byte());
      end
      4: begin
        body.push_back(CHAR_M);
        repeat (2) body.push_back(rand_byte());
      end
      5: begin
        repeat ($urandom_range(1, 5)) body.push_back(rand_byte());
      end
      default: begin
      end
    endcase
    if (body.size() > 1 && $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, body.size() - 1);
      repeat (cut) body.delete(body.size() - 1);
    end
    send_byte(CHAR_OPEN);
    foreach (body[i]) send_byte(body[i]);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(rand_byte());
    end
    send_byte(CHAR_CLOSE);
  endtask

  task automatic test_random_traffic(input int target);
    int  chunk_end;
    bit  first;
    first = 1'b1;
    while (rx_count < target) begin
      if (first) begin
        rcv_mode = RCV_ALWAYS;
        gap_max  = 0;
        first    = 1'b0;
      end else begin
        rcv_mode = $urandom_range(RCV_ALWAYS, RCV_PATTERN);
        gap_max  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      chunk_end = rx_count + $urandom_range(30, 90);
      while (rx_count < chunk_end && rx_count < target) begin
        send_random_frame();
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats, so the result register fills and the input stalls.
  task automatic test_output_stall();
    gap_max  = 0;
    hold_len = LONG_HOLD;
    hold_req = 1'b1;
    repeat (10) send_random_frame();
  endtask

  task automatic test_drain_pause();
    rcv_mode = RCV_RANDOM;
    gap_max  = 3;
    repeat (4) send_random_frame();
    wait_drained();
    repeat (3) send_random_frame();
  endtask

  initial begin
    cmd_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        cmd_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        rcv_cycle++;
        case (rcv_mode)
          RCV_RANDOM:  cmd_ch.ready <= ($urandom_range(0, 3) != 0);
          RCV_PATTERN: cmd_ch.ready <= ((rcv_cycle % 7) < 4);
          default:     cmd_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected command", 64'(cmd_ch.cmd_kind), 64'd0);
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (cmd_ch.cmd_kind !== want_cmd.kind)
          report_mismatch("cmd_kind", 64'(cmd_ch.cmd_kind), 64'(want_cmd.kind));
        if (cmd_ch.money_value !== want_cmd.money)
          report_mismatch("money_value", 64'(cmd_ch.money_value), 64'(want_cmd.money));
        if (cmd_ch.hunger_level !== want_cmd.hunger)
          report_mismatch("hunger_level", 64'(cmd_ch.hunger_level), 64'(want_cmd.hunger));
        if (cmd_ch.happy_level !== want_cmd.happy)
          report_mismatch("happy_level", 64'(cmd_ch.happy_level), 64'(want_cmd.happy));
        if (cmd_ch.thirst_level !== want_cmd.thirst)
          report_mismatch("thirst_level", 64'(cmd_ch.thirst_level), 64'(want_cmd.thirst));
        if (cmd_ch.alert_text !== want_cmd.text)
          report_mismatch("alert_text", cmd_ch.alert_text, want_cmd.text);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** brace_frame_command_decoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      frame_copy[i] = '0;
    end
    wr_pos    = 0;
    open_pos  = 0;
    open_flag = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_stale_after_reset();
    test_go();
    test_end();
    test_sensor();
    test_alert();
    test_payment();
    test_unknown();
    test_no_open();
    test_store_full();
    test_random_traffic(TARGET_BYTES / 2);
    test_output_stall();
    test_drain_pause();
    test_random_traffic(TARGET_BYTES);

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** brace_frame_command_decoder: PASSED **");
    end else begin
      $display("** brace_frame_command_decoder: FAILED **");
    end
    $finish;
  end

endmodule
